[rtl/assert_macros.svh]
// Assertion macros used by the top level of the upsampling smoother.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// pre in this cycle implies post in this cycle
`define CUS_ASSERT_IMP(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("cus: assertion failed");

// pre in this cycle implies post in the next cycle
`define CUS_ASSERT_NXT(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("cus: assertion failed");

`endif

[rtl/cus_pkg.sv]
// Types and constants of the cyclic upsampling smoother.
// No dependencies; used by the interfaces and every module of the block.
package cus_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int POS_W      = 15;
    localparam int WEIGHT_W   = 17;
    localparam int FACTOR_W   = 6;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 17;
    localparam int MAG_W      = 16;
    localparam int PROD_W     = 35;

    localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = 17'h10000;
    localparam logic [POS_W-1:0]    POS_MAX    = 15'h7FFF;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WEIGHT = 1'b0,
        REG_FACTOR = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       end_of_record;
    } in_item_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] value;
        logic [POS_W-1:0]           position;
        logic                       final_res;
    } out_item_t;

    // where the value of the result in flight comes from
    typedef enum logic [1:0] {
        SRC_INTERP,
        SRC_SAMPLE,
        SRC_FIRST
    } src_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FIRST,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_SEG_LOAD,
        ST_PREP,
        ST_MUL,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic capture;
        logic seed;
        logic div_start;
        logic seg_wrap;
        logic seg_load;
        logic prep;
        logic mul;
        logic out_load;
        src_t src;
    } cmd_t;

    typedef struct packed {
        logic started;
        logic eor;
        logic div_busy;
        logic j_done;
        logic out_free;
    } status_t;

endpackage

[rtl/cus_if.sv]
// Handshake channels of the cyclic upsampling smoother: input items,
// result items and configuration writes. Depends on cus_pkg.
interface cus_in_if;
    logic               valid;
    logic               ready;
    cus_pkg::in_item_t  payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface cus_out_if;
    logic               valid;
    logic               ready;
    cus_pkg::out_item_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface cus_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [cus_pkg::CFG_IDX_W-1:0]     index;
    logic [cus_pkg::CFG_DATA_W-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

[rtl/cyclic_upsample_smoother.sv]
// Cyclic upsampling smoother: each sample of a cyclic record ends a segment
// that yields upsample_factor linearly interpolated values, each passed through
// a one-pole Q16 smoother; index 0 is held back and closes the record with
// final_res set. One item is in work at a time. The first sample of a record
// seeds the record state; any later sample runs the divider once for its
// segment, then a prepare, multiply and output step per result, and a closing
// sample adds a second segment of the same length. The output register lets
// the last result wait for the sink while the next item is taken.
// Configuration is taken at any time and must change only while idle.
// Depends on cus_pkg, cus_if, cus_ctrl, cus_dp and assert_macros.svh.
`include "assert_macros.svh"

module cyclic_upsample_smoother #(
    parameter int MAX_FACTOR = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    cus_cfg_if.sink     cfg,
    cus_in_if.sink      samples,
    cus_out_if.source   results
);

    localparam int FW = cus_pkg::FACTOR_W;
    localparam logic [FW-1:0] FACTOR_MAX = FW'(MAX_FACTOR);

    logic [cus_pkg::WEIGHT_W-1:0] weight_reg;
    logic [FW-1:0]                factor_reg;
    logic [cus_pkg::WEIGHT_W-1:0] weight_eff;
    logic [FW-1:0]                factor_eff;

    cus_pkg::cmd_t    cmd;
    cus_pkg::status_t status;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            weight_reg <= '0;
            factor_reg <= FW'(1);
        end
        else if (cfg.valid)
        begin
            unique case (cus_pkg::cfg_reg_t'(cfg.index))
                cus_pkg::REG_WEIGHT: weight_reg <= cfg.data[cus_pkg::WEIGHT_W-1:0];
                cus_pkg::REG_FACTOR: factor_reg <= cfg.data[FW-1:0];
                default:             factor_reg <= factor_reg;
            endcase
        end
    end

    // clamp weight to one and factor to 1..MAX_FACTOR
    assign weight_eff = (weight_reg > cus_pkg::WEIGHT_ONE) ? cus_pkg::WEIGHT_ONE : weight_reg;

    always_comb
    begin
        priority if (factor_reg == '0)
        begin
            factor_eff = FW'(1);
        end
        else if (factor_reg > FACTOR_MAX)
        begin
            factor_eff = FACTOR_MAX;
        end
        else
        begin
            factor_eff = factor_reg;
        end
    end

    cus_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (samples.valid),
        .in_ready (samples.ready),
        .status   (status),
        .cmd      (cmd)
    );

    cus_dp #(
        .MAX_FACTOR (MAX_FACTOR)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .in_item   (samples.payload),
        .weight    (weight_eff),
        .factor    (factor_eff),
        .out_item  (results.payload),
        .out_valid (results.valid),
        .out_ready (results.ready)
    );

    `CUS_ASSERT_IMP(a_final_at_zero, results.valid && results.payload.final_res, results.payload.position == '0)
    `CUS_ASSERT_NXT(a_one_item, samples.valid && samples.ready, !samples.ready)
    `CUS_ASSERT_IMP(a_load_when_free, cmd.out_load, status.out_free)

endmodule

[rtl/cus_div.sv]
// Restoring divider, one quotient bit per cycle: segment span over factor.
// Depends on cus_pkg for the operand widths.
module cus_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [cus_pkg::MAG_W-1:0]     dividend,
    input  logic [cus_pkg::FACTOR_W-1:0]  divisor,
    output logic                          busy,
    output logic [cus_pkg::MAG_W-1:0]     quot,
    output logic [cus_pkg::FACTOR_W-1:0]  rem
);

    localparam int STEPS = cus_pkg::MAG_W;
    localparam int CW    = $clog2(STEPS + 1);
    localparam int FW    = cus_pkg::FACTOR_W;

    logic [CW-1:0]    cnt_reg;
    logic             busy_reg;
    logic [STEPS-1:0] quot_reg;
    logic [FW-1:0]    rem_reg;
    logic [FW-1:0]    div_reg;

    logic [FW:0]      trial;
    logic             ge;
    logic [FW-1:0]    rem_next;

    assign trial    = {rem_reg, quot_reg[STEPS-1]};
    assign ge       = trial >= {1'b0, div_reg};
    assign rem_next = ge ? FW'(trial - {1'b0, div_reg}) : trial[FW-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= CW'(STEPS);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quot_reg <= dividend;
            rem_reg  <= '0;
            div_reg  <= divisor;
        end
        else if (busy_reg)
        begin
            quot_reg <= {quot_reg[STEPS-2:0], ge};
            rem_reg  <= rem_next;
        end
    end

    assign busy = busy_reg;
    assign quot = quot_reg;
    assign rem  = rem_reg;

endmodule

[rtl/cus_dp.sv]
// Datapath of the upsampling smoother: record state, segment stepping,
// smoothing multiply-add and the output register. Depends on cus_pkg, cus_div.
module cus_dp #(
    parameter int MAX_FACTOR = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  cus_pkg::cmd_t                     cmd,
    output cus_pkg::status_t                  status,
    input  cus_pkg::in_item_t                 in_item,
    input  logic [cus_pkg::WEIGHT_W-1:0]      weight,
    input  logic [cus_pkg::FACTOR_W-1:0]      factor,
    output cus_pkg::out_item_t                out_item,
    output logic                              out_valid,
    input  logic                              out_ready
);

    localparam int JW = $clog2(MAX_FACTOR + 1);
    localparam int FW = cus_pkg::FACTOR_W;
    localparam int SW = cus_pkg::SAMPLE_W;
    localparam int MW = cus_pkg::MAG_W;
    localparam int PW = cus_pkg::PROD_W;

    // captured item
    logic signed [SW-1:0] sample_reg;
    logic                 eor_reg;

    // record state
    logic signed [SW-1:0]          first_reg;
    logic signed [SW-1:0]          prev_reg;
    logic signed [SW-1:0]          smooth_reg;
    logic                          started_reg;
    logic [cus_pkg::POS_W-1:0]     count_reg;

    // segment state
    logic signed [SW-1:0] a_reg;
    logic                 neg_reg;
    logic [MW-1:0]        q_reg;
    logic [FW-1:0]        rem_reg;
    logic [JW-1:0]        j_reg;

    // smoothing pipeline
    logic signed [SW-1:0] r_reg;
    logic signed [PW-1:0] prod_reg;

    cus_pkg::out_item_t   out_reg;
    logic                 out_valid_reg;

    // divider
    logic signed [SW:0]   seg_b;
    logic signed [SW:0]   seg_diff;
    logic [MW-1:0]        seg_mag;
    logic                 div_busy;
    logic [MW-1:0]        div_quot;
    logic [FW-1:0]        div_rem;

    logic [FW:0]          rem_sum;
    logic                 q_carry;
    logic signed [SW+1:0] interp_wide;
    logic signed [SW-1:0] r_next;
    logic signed [SW:0]   mul_diff;
    logic signed [PW-1:0] prod_next;
    logic signed [PW:0]   t_sum;
    logic signed [PW-16:0] y_wide;
    logic signed [SW-1:0] y_sat;

    assign seg_b    = cmd.seg_wrap ? {first_reg[SW-1], first_reg} : {sample_reg[SW-1], sample_reg};
    assign seg_diff = seg_b - {prev_reg[SW-1], prev_reg};
    assign seg_mag  = seg_diff[SW] ? MW'(-seg_diff) : MW'(seg_diff);

    cus_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (seg_mag),
        .divisor  (factor),
        .busy     (div_busy),
        .quot     (div_quot),
        .rem      (div_rem)
    );

    // step the magnitude |b - a| * j / factor by quotient and remainder
    assign rem_sum = {1'b0, rem_reg} + {1'b0, div_rem};
    assign q_carry = rem_sum >= {1'b0, factor};

    assign interp_wide = neg_reg ? ({{2{a_reg[SW-1]}}, a_reg} - {2'b00, q_reg})
                                 : ({{2{a_reg[SW-1]}}, a_reg} + {2'b00, q_reg});

    always_comb
    begin
        unique case (cmd.src)
            cus_pkg::SRC_INTERP: r_next = interp_wide[SW-1:0];
            cus_pkg::SRC_SAMPLE: r_next = sample_reg;
            cus_pkg::SRC_FIRST:  r_next = first_reg;
            default:             r_next = sample_reg;
        endcase
    end

    // y = (w * yprev + (1 - w) * r) written as r + w * (yprev - r)
    assign mul_diff  = {smooth_reg[SW-1], smooth_reg} - {r_reg[SW-1], r_reg};
    assign prod_next = $signed({1'b0, weight}) * mul_diff;

    assign t_sum  = $signed({{4{r_reg[SW-1]}}, r_reg, 16'h0000})
                  + $signed({prod_reg[PW-1], prod_reg})
                  + $signed((PW+1)'(32768));
    assign y_wide = t_sum[PW:16];

    always_comb
    begin
        priority if (y_wide > $signed((PW-15)'(32767)))
        begin
            y_sat = 16'sh7FFF;
        end
        else if (y_wide < -$signed((PW-15)'(32768)))
        begin
            y_sat = 16'sh8000;
        end
        else
        begin
            y_sat = y_wide[SW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_reg <= '0;
            eor_reg    <= 1'b0;
        end
        else if (cmd.capture)
        begin
            sample_reg <= in_item.sample;
            eor_reg    <= in_item.end_of_record;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_reg   <= '0;
            prev_reg    <= '0;
            smooth_reg  <= '0;
            started_reg <= 1'b0;
            count_reg   <= '0;
        end
        else if (cmd.seed)
        begin
            first_reg   <= sample_reg;
            prev_reg    <= sample_reg;
            smooth_reg  <= sample_reg;
            started_reg <= 1'b1;
            count_reg   <= cus_pkg::POS_W'(1);
        end
        else if (cmd.out_load)
        begin
            if (cmd.src == cus_pkg::SRC_FIRST)
            begin
                // record closed: back to the reset state
                first_reg   <= '0;
                prev_reg    <= '0;
                smooth_reg  <= '0;
                started_reg <= 1'b0;
                count_reg   <= '0;
            end
            else
            begin
                smooth_reg <= y_sat;
                if (count_reg != cus_pkg::POS_MAX)
                begin
                    count_reg <= count_reg + 1'b1;
                end
                if (cmd.src == cus_pkg::SRC_SAMPLE)
                begin
                    prev_reg <= sample_reg;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.div_start)
        begin
            a_reg   <= prev_reg;
            neg_reg <= seg_diff[SW];
        end
        if (cmd.seg_load)
        begin
            q_reg   <= div_quot;
            rem_reg <= div_rem;
        end
        else if (cmd.prep && cmd.src == cus_pkg::SRC_INTERP)
        begin
            q_reg   <= q_reg + div_quot + MW'(q_carry);
            rem_reg <= q_carry ? FW'(rem_sum - {1'b0, factor}) : rem_sum[FW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            j_reg <= '0;
        end
        else if (cmd.seg_load)
        begin
            j_reg <= JW'(1);
        end
        else if (cmd.prep && cmd.src == cus_pkg::SRC_INTERP)
        begin
            j_reg <= j_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.prep)
        begin
            r_reg <= r_next;
        end
        if (cmd.mul)
        begin
            prod_reg <= prod_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_reg.value     <= y_sat;
            out_reg.position  <= (cmd.src == cus_pkg::SRC_FIRST) ? '0 : count_reg;
            out_reg.final_res <= (cmd.src == cus_pkg::SRC_FIRST);
        end
    end

    assign status.started  = started_reg;
    assign status.eor      = eor_reg;
    assign status.div_busy = div_busy;
    assign status.j_done   = (FW'(j_reg) >= factor);
    assign status.out_free = !out_valid_reg || out_ready;

    assign out_item  = out_reg;
    assign out_valid = out_valid_reg;

endmodule

[rtl/cus_ctrl.sv]
// Sequencer of the upsampling smoother: walks each item through seeding,
// segment division, interpolation steps and result hand-off. Depends on cus_pkg.
module cus_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  cus_pkg::status_t  status,
    output cus_pkg::cmd_t     cmd
);

    cus_pkg::state_t state_reg, state_next;
    cus_pkg::src_t   src_reg, src_next;
    logic            wrap_reg, wrap_next;
    cus_pkg::src_t   prep_src;

    // interior values first, then the segment end point
    assign prep_src = !status.j_done ? cus_pkg::SRC_INTERP
                    : (wrap_reg ? cus_pkg::SRC_FIRST : cus_pkg::SRC_SAMPLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= cus_pkg::ST_IDLE;
            src_reg   <= cus_pkg::SRC_INTERP;
            wrap_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            src_reg   <= src_next;
            wrap_reg  <= wrap_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        src_next   = src_reg;
        wrap_next  = wrap_reg;
        unique case (state_reg)
            cus_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    wrap_next  = 1'b0;
                    state_next = status.started ? cus_pkg::ST_DIV_START : cus_pkg::ST_FIRST;
                end
            end
            cus_pkg::ST_FIRST:
            begin
                if (status.eor)
                begin
                    wrap_next  = 1'b1;
                    state_next = cus_pkg::ST_DIV_START;
                end
                else
                begin
                    state_next = cus_pkg::ST_IDLE;
                end
            end
            cus_pkg::ST_DIV_START: state_next = cus_pkg::ST_DIV_WAIT;
            cus_pkg::ST_DIV_WAIT:
            begin
                if (!status.div_busy)
                begin
                    state_next = cus_pkg::ST_SEG_LOAD;
                end
            end
            cus_pkg::ST_SEG_LOAD: state_next = cus_pkg::ST_PREP;
            cus_pkg::ST_PREP:
            begin
                src_next   = prep_src;
                state_next = cus_pkg::ST_MUL;
            end
            cus_pkg::ST_MUL: state_next = cus_pkg::ST_OUT;
            cus_pkg::ST_OUT:
            begin
                if (status.out_free)
                begin
                    unique case (src_reg)
                        cus_pkg::SRC_INTERP: state_next = cus_pkg::ST_PREP;
                        cus_pkg::SRC_SAMPLE:
                        begin
                            if (status.eor)
                            begin
                                wrap_next  = 1'b1;
                                state_next = cus_pkg::ST_DIV_START;
                            end
                            else
                            begin
                                state_next = cus_pkg::ST_IDLE;
                            end
                        end
                        cus_pkg::SRC_FIRST:  state_next = cus_pkg::ST_IDLE;
                        default:             state_next = cus_pkg::ST_IDLE;
                    endcase
                end
            end
            default: state_next = cus_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd           = '0;
        cmd.src       = cus_pkg::SRC_INTERP;
        cmd.seg_wrap  = wrap_reg;
        in_ready      = 1'b0;
        unique case (state_reg)
            cus_pkg::ST_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
            end
            cus_pkg::ST_FIRST:     cmd.seed      = 1'b1;
            cus_pkg::ST_DIV_START: cmd.div_start = 1'b1;
            cus_pkg::ST_DIV_WAIT:  cmd.seed      = 1'b0;
            cus_pkg::ST_SEG_LOAD:  cmd.seg_load  = 1'b1;
            cus_pkg::ST_PREP:
            begin
                cmd.prep = 1'b1;
                cmd.src  = prep_src;
            end
            cus_pkg::ST_MUL:       cmd.mul       = 1'b1;
            cus_pkg::ST_OUT:
            begin
                cmd.out_load = status.out_free;
                cmd.src      = src_reg;
            end
            default:               cmd.seed      = 1'b0;
        endcase
    end

endmodule
